### sv/rwt_pkg.sv
// Shared types, character codes and helpers for the record word tokenizer.
// No dependencies; every other file in this block imports this package.
`default_nettype none

package rwt_pkg;

    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        TK_BYTE = 2'd0,
        TK_EOW  = 2'd1,
        TK_EOR  = 2'd2,
        TK_EOI  = 2'd3
    } t_token_kind;

    typedef struct packed {
        t_token_kind kind;
        logic [7:0]  word_byte;
    } t_result;

    typedef struct packed {
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_burst;

    function automatic t_result mk_res(input t_token_kind k, input logic [7:0] b);
        t_result r;
        r.kind      = k;
        r.word_byte = (k == TK_BYTE) ? b : 8'h00;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/rwt_scan.sv
// Scan mode register and the per-byte decoder that turns one request into
// a burst of up to three results. Depends on rwt_pkg.
`default_nettype none

module rwt_scan (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_data_byte,
    output rwt_pkg::t_burst      o_burst
);
    import rwt_pkg::*;

    typedef enum logic [2:0] {
        M_GAP  = 3'd0,
        M_WORD = 3'd1,
        M_CMT  = 3'd2,
        M_BS   = 3'd3,
        M_BSCR = 3'd4
    } t_mode;

    t_mode       r_mode;
    t_mode       n_mode;
    t_burst      n_burst;
    logic [7:0]  b;
    logic        is_ws;
    logic        is_lf;
    logic        is_cr;
    logic        g_emit;
    t_result     g_res;
    t_mode       g_mode;

    assign b     = i_data_byte;
    assign is_ws = (b == CH_SPACE) || (b == CH_TAB);
    assign is_lf = (b == CH_LF);
    assign is_cr = (b == CH_CR);

    // Handling of a byte that arrives between words.
    always_comb begin
        g_emit = 1'b0;
        g_res  = mk_res(TK_EOR, 8'h00);
        g_mode = M_GAP;
        if (is_ws || is_cr) begin
            g_mode = M_GAP;
        end else if (is_lf) begin
            g_emit = 1'b1;
        end else if (b == CH_HASH) begin
            g_mode = M_CMT;
        end else if (b == CH_BSLASH) begin
            g_mode = M_BS;
        end else begin
            g_emit = 1'b1;
            g_res  = mk_res(TK_BYTE, b);
            g_mode = M_WORD;
        end
    end

    always_comb begin
        n_burst       = '0;
        n_mode        = r_mode;
        if (i_kind == KIND_END) begin
            n_mode = M_GAP;
            case (r_mode)
                M_WORD: begin
                    n_burst.res[0] = mk_res(TK_EOW, 8'h00);
                    n_burst.res[1] = mk_res(TK_EOI, 8'h00);
                    n_burst.count  = 2'd2;
                end
                M_BS, M_BSCR: begin
                    n_burst.res[0] = mk_res(TK_BYTE, CH_BSLASH);
                    n_burst.res[1] = mk_res(TK_EOW, 8'h00);
                    n_burst.res[2] = mk_res(TK_EOI, 8'h00);
                    n_burst.count  = 2'd3;
                end
                default: begin
                    n_burst.res[0] = mk_res(TK_EOI, 8'h00);
                    n_burst.count  = 2'd1;
                end
            endcase
        end else begin
            case (r_mode)
                M_WORD: begin
                    if (is_ws || is_cr || is_lf) begin
                        n_burst.res[0] = mk_res(TK_EOW, 8'h00);
                        n_burst.res[1] = mk_res(TK_EOR, 8'h00);
                        n_burst.count  = is_lf ? 2'd2 : 2'd1;
                        n_mode         = M_GAP;
                    end else begin
                        n_burst.res[0] = mk_res(TK_BYTE, b);
                        n_burst.count  = 2'd1;
                    end
                end
                M_CMT: begin
                    if (is_lf) begin
                        n_burst.res[0] = mk_res(TK_EOR, 8'h00);
                        n_burst.count  = 2'd1;
                        n_mode         = M_GAP;
                    end
                end
                M_BS: begin
                    if (is_lf) begin
                        n_mode = M_GAP;
                    end else if (is_cr) begin
                        n_mode = M_BSCR;
                    end else begin
                        n_burst.res[0] = mk_res(TK_BYTE, CH_BSLASH);
                        n_burst.count  = 2'd2;
                        if (is_ws) begin
                            n_burst.res[1] = mk_res(TK_EOW, 8'h00);
                            n_mode         = M_GAP;
                        end else begin
                            n_burst.res[1] = mk_res(TK_BYTE, b);
                            n_mode         = M_WORD;
                        end
                    end
                end
                M_BSCR: begin
                    if (is_lf) begin
                        n_mode = M_GAP;
                    end else begin
                        n_burst.res[0] = mk_res(TK_BYTE, CH_BSLASH);
                        n_burst.res[1] = mk_res(TK_EOW, 8'h00);
                        n_burst.res[2] = g_res;
                        n_burst.count  = g_emit ? 2'd3 : 2'd2;
                        n_mode         = g_mode;
                    end
                end
                default: begin
                    n_burst.res[0] = g_res;
                    n_burst.count  = g_emit ? 2'd1 : 2'd0;
                    n_mode         = g_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_GAP;
        end else if (i_take) begin
            r_mode <= n_mode;
        end
    end

    assign o_burst = n_burst;

endmodule

`default_nettype wire

### sv/rwt_burst.sv
// Result register that holds one burst and hands its results out one per cycle
// unless stalled, taking a new burst as the last one leaves. Depends on rwt_pkg.
`default_nettype none

module rwt_burst (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire rwt_pkg::t_burst i_burst,
    input  wire logic            i_out_stall,
    output logic                 o_can_load,
    output logic                 o_out_valid,
    output rwt_pkg::t_result     o_result,
    output logic                 o_out_last
);
    import rwt_pkg::*;

    logic [1:0]                r_count;
    t_result [MAX_RESULTS-1:0] r_res;
    logic                      fire;

    assign o_out_valid = (r_count != 2'd0);
    assign fire        = o_out_valid && !i_out_stall;
    assign o_can_load  = (r_count == 2'd0) || ((r_count == 2'd1) && !i_out_stall);
    assign o_result    = r_res[0];
    assign o_out_last  = (r_count == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_load) begin
            r_count <= i_burst.count;
        end else if (fire) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end else if (fire) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

`default_nettype wire

### sv/record_word_tokenizer_unit.sv
// Top level of the record word tokenizer: scan decoder plus result register.
// Depends on rwt_pkg, rwt_scan and rwt_burst.
//
// The block takes one text byte (or an end-of-input mark) per request and
// emits word bytes, end-of-word, end-of-record and end-of-input tokens, with
// o_last set on the final token of each request. A request that yields zero
// or one token is taken every cycle while the output is not stalled; one
// that yields two or three tokens holds the input until its last token
// leaves, since the result register hands out one token per unstalled cycle.
`default_nettype none

module record_word_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_token_kind,
    output logic [7:0]       o_word_byte,
    output logic             o_last
);
    import rwt_pkg::*;

    logic    can_load;
    logic    take;
    t_burst  burst;
    t_result result;

    assign o_stall = !can_load;
    assign take    = i_valid && can_load;

    rwt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_burst     (burst)
    );

    rwt_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_burst     (burst),
        .i_out_stall (i_stall),
        .o_can_load  (can_load),
        .o_out_valid (o_valid),
        .o_result    (result),
        .o_out_last  (o_last)
    );

    assign o_token_kind = result.kind;
    assign o_word_byte  = result.word_byte;

endmodule

`default_nettype wire
